// File: design/pdbr_pkg.sv
// Package for the packet drain byte ring: sizes, beat types and pointer helpers.
`default_nettype none
package pdbr_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int PACKET_MAX = 64;

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int LEN_W  = 16;
  localparam int BYTE_W = 8;
  localparam int PLEN_W = 7;
  localparam int CMP_W  = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PUMP  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_msg;
    logic [LEN_W-1:0]  msg_len;
    logic              link_ready;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic [PLEN_W-1:0] packet_len;
    logic              last_in_packet;
  } out_t;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/packet_drain_byte_ring.sv
// Top level of the packet drain byte ring: pointer control, message admission and drain sequencer.
//
// Items are taken when start is high and busy is low. A write item gives no beat. A pump that
// finds data with link_ready high reads n = min(used, 64) bytes from the ring RAM, one address
// per cycle starting in the accept cycle, so busy stays high until the last address is issued;
// each byte leaves on result_o in the cycle after its read (the RAM's registered read port),
// marked by result_valid_o for a single cycle. Beats cannot be held off by the receiver. An
// empty or unready pump gives no beat. No clearing pass is run after reset; only written ring
// slots are ever read.
`default_nettype none
module packet_drain_byte_ring import pdbr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output      logic busy,
  input  wire in_t  in_i,
  output      logic result_valid_o,
  output      out_t result_o
);

  state_e state_q, state_d;

  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic              drop_q, drop_d;
  logic [PLEN_W-1:0] cnt_q, cnt_d;
  logic [PLEN_W-1:0] n_q, n_d;
  logic              vld_q, vld_d;
  logic              last_q, last_d;
  logic [PLEN_W-1:0] olen_q, olen_d;

  logic              accept;
  logic              pump_go;
  logic              we;
  logic [CMP_W-1:0]  used_c;
  logic [CMP_W-1:0]  free_c;
  logic [PLEN_W-1:0] n_c;
  logic [BYTE_W-1:0] rdata;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    used_c = CMP_W'(wptr_q) - CMP_W'(rptr_q);
    if (wptr_q < rptr_q) begin
      used_c = used_c + CMP_W'(RING_DEPTH);
    end
    free_c = CMP_W'(RING_DEPTH - 1) - used_c;
    if (used_c > CMP_W'(PACKET_MAX)) begin
      n_c = PLEN_W'(PACKET_MAX);
    end else begin
      n_c = used_c[PLEN_W-1:0];
    end
  end

  assign pump_go = accept && (in_i.op == OP_PUMP) && in_i.link_ready && (used_c != '0);

  always_comb begin
    state_d = state_q;
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    rem_d   = rem_q;
    drop_d  = drop_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    vld_d   = 1'b0;
    last_d  = 1'b0;
    olen_d  = olen_q;
    we      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.op == OP_WRITE)) begin
          if (in_i.first_of_msg) begin
            if (in_i.msg_len == '0) begin
              rem_d  = '0;
              drop_d = 1'b0;
            end else begin
              rem_d  = in_i.msg_len - 1'b1;
              drop_d = (CMP_W'(in_i.msg_len) > free_c);
              we     = !(CMP_W'(in_i.msg_len) > free_c) && (free_c != '0);
            end
          end else if (rem_q != '0) begin
            rem_d = rem_q - 1'b1;
            we    = !drop_q && (free_c != '0);
          end
          if (we) begin
            wptr_d = bump(wptr_q);
          end
        end else if (pump_go) begin
          rptr_d = bump(rptr_q);
          cnt_d  = PLEN_W'(1);
          n_d    = n_c;
          vld_d  = 1'b1;
          olen_d = n_c;
          last_d = (n_c == PLEN_W'(1));
          if (n_c != PLEN_W'(1)) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        rptr_d = bump(rptr_q);
        cnt_d  = cnt_q + 1'b1;
        vld_d  = 1'b1;
        last_d = (cnt_q == n_q - 1'b1);
        if (cnt_q == n_q - 1'b1) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      rem_q  <= '0;
      drop_q <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
      vld_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      rem_q  <= rem_d;
      drop_q <= drop_d;
      cnt_q  <= cnt_d;
      n_q    <= n_d;
      vld_q  <= vld_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    olen_q <= olen_d;
  end

  pdbr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wptr_q),
    .wdata_i (in_i.data_byte),
    .raddr_i (rptr_q),
    .rdata_o (rdata)
  );

  assign result_valid_o            = vld_q;
  assign result_o.tx_byte          = rdata;
  assign result_o.packet_len       = olen_q;
  assign result_o.last_in_packet   = last_q;

  // a beat only follows a read issued by an accepted pump or the drain sequence
  a_beat_has_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> $past(pump_go || (state_q == ST_DRAIN)))
    else $error("beat without a preceding ring read");

  a_drain_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (cnt_q < n_q))
    else $error("drain count past packet length");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (wptr_q != rptr_q))
    else $error("drain reads from an empty ring");

  a_no_write_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> $stable(wptr_q))
    else $error("write pointer moved during drain");

endmodule
`default_nettype wire

// File: design/pdbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pdbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
